// ===== sv/lrd_pkg.sv =====
// Shared types, constants and address helpers for the line/rectangle drawer.
// Used by lrd_front, lrd_queue, lrd_back and the top level.
package lrd_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
	localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
	localparam int ADDR_W        = $clog2(STORE_BYTES);
	localparam int IN_W          = 11;
	localparam int COORD_W       = 12;
	localparam int ERR_W         = 13;
	localparam int QDEPTH        = 2;

	typedef enum logic [1:0] {
		CMD_LINE  = 2'd0,
		CMD_RECT  = 2'd1,
		CMD_READ  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_TOGGLE = 2'd2,
		MODE_KEEP   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_LINE,
		BK_RECT,
		BK_CLEAR,
		BK_RDWAIT
	} back_state_t;

	typedef logic signed [COORD_W-1:0] coord_t;

	// One classified command. Line: p0 is the start in walk axes (u, v).
	// Rect: p0 is the clipped low corner, p1 the clipped high corner.
	// Read: p0 is the addressed pixel.
	typedef struct packed {
		cmd_t                 cmd;
		mode_t                mode;
		coord_t               p0x;
		coord_t               p0y;
		coord_t               p1x;
		coord_t               p1y;
		logic [COORD_W-1:0]   dx;
		logic [COORD_W-1:0]   dy;
		logic                 steep;
		logic                 neg;
		logic                 skip;
	} desc_t;

	function automatic logic on_screen(coord_t x, coord_t y);
		return (x >= 0) && (x < coord_t'(SCREEN_WIDTH)) &&
			(y >= 0) && (y < coord_t'(SCREEN_HEIGHT));
	endfunction

	function automatic logic [ADDR_W-1:0] pixel_addr(coord_t x, coord_t y);
		int unsigned a;
		a = 32'($unsigned(y[COORD_W-1:3])) * SCREEN_WIDTH + 32'($unsigned(x));
		return a[ADDR_W-1:0];
	endfunction

endpackage

// ===== sv/lrd_front.sv =====
// Front end: accepts commands, orders line endpoints and clips rectangles.
// Depends on lrd_pkg; feeds lrd_queue.
module lrd_front import lrd_pkg::*; (
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic signed [IN_W-1:0] point_a_x,
	input  logic signed [IN_W-1:0] point_a_y,
	input  logic signed [IN_W-1:0] point_b_x,
	input  logic signed [IN_W-1:0] point_b_y,
	input  logic [1:0]             draw_mode,
	input  logic                   q_full,
	output logic                   q_push,
	output desc_t                  q_desc
);

	coord_t ax, ay, bx, by, ddx, ddy;
	coord_t u0, v0, u1, v1, sx, sy, ey;
	coord_t lx, hx, ly, hy;
	logic [COORD_W-1:0] adx, ady;
	logic steep;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		ax = {point_a_x[IN_W-1], point_a_x};
		ay = {point_a_y[IN_W-1], point_a_y};
		bx = {point_b_x[IN_W-1], point_b_x};
		by = {point_b_y[IN_W-1], point_b_y};
		ddx = bx - ax;
		ddy = by - ay;
		adx = (ddx < 0) ? $unsigned(-ddx) : $unsigned(ddx);
		ady = (ddy < 0) ? $unsigned(-ddy) : $unsigned(ddy);
		steep = ady > adx;
		u0 = steep ? ay : ax;
		v0 = steep ? ax : ay;
		u1 = steep ? by : bx;
		v1 = steep ? bx : by;
		// order the endpoints so u rises
		if (u0 > u1) begin
			sx = u1;
			sy = v1;
			ey = v0;
		end else begin
			sx = u0;
			sy = v0;
			ey = v1;
		end
		lx = (ax < bx) ? ax : bx;
		hx = (ax < bx) ? bx : ax;
		ly = (ay < by) ? ay : by;
		hy = (ay < by) ? by : ay;
		if (lx < 0) lx = '0;
		if (ly < 0) ly = '0;
		if (hx > coord_t'(SCREEN_WIDTH - 1)) hx = coord_t'(SCREEN_WIDTH - 1);
		if (hy > coord_t'(SCREEN_HEIGHT - 1)) hy = coord_t'(SCREEN_HEIGHT - 1);

		q_desc.cmd   = cmd_t'(command);
		q_desc.mode  = mode_t'(draw_mode);
		q_desc.dx    = steep ? ady : adx;
		q_desc.dy    = steep ? adx : ady;
		q_desc.steep = steep;
		q_desc.neg   = sy > ey;
		q_desc.p0x   = sx;
		q_desc.p0y   = sy;
		q_desc.p1x   = '0;
		q_desc.p1y   = '0;
		q_desc.skip  = 1'b0;
		case (cmd_t'(command))
			CMD_RECT: begin
				q_desc.p0x  = lx;
				q_desc.p0y  = ly;
				q_desc.p1x  = hx;
				q_desc.p1y  = hy;
				q_desc.skip = (lx > hx) || (ly > hy);
			end
			CMD_READ: begin
				q_desc.p0x  = ax;
				q_desc.p0y  = ay;
				q_desc.skip = !on_screen(ax, ay);
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/lrd_queue.sv =====
// Two-entry command queue between the front end and the pixel engine.
// Depends on lrd_pkg for the descriptor type.
module lrd_queue import lrd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output desc_t head
);

	localparam int PTR_W = $clog2(QDEPTH);

	desc_t entries_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]   count_q;

	assign full  = count_q == (PTR_W + 1)'(QDEPTH);
	assign valid = count_q != '0;
	assign head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_desc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== sv/lrd_back.sv =====
// Pixel engine: walks lines and rectangles, one read-modify-write per cycle,
// clears the store and answers reads. Holds the frame store. Depends on lrd_pkg.
module lrd_back import lrd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  desc_t       q_head,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	back_state_t state_q, state_d;

	// walker
	coord_t wx_q, wy_q, lim_x_q, lim_y_q, base_y_q;
	logic signed [ERR_W-1:0] err_q, e2;
	logic [COORD_W-1:0] cnt_q, dx_q, dy_q;
	logic steep_q, neg_q;
	mode_t mode_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic clr_res_q;

	// pixel pipeline
	logic s1_valid_s1, s1_read_s1;
	logic [ADDR_W-1:0] s1_addr_s1;
	logic [7:0] s1_mask_s1;
	mode_t s1_mode_s1;
	logic [7:0] mem [STORE_BYTES];
	logic [7:0] mem_rd_q, base_byte, new_byte, wr_data_q;
	logic [ADDR_W-1:0] wr_addr_q;
	logic wr_valid_q, s2_we;

	logic out_valid_q;
	logic [7:0] read_data_q;

	logic start, line_last, rect_last, clr_last;
	logic issue, issue_read, emit, clear_we;
	logic [ADDR_W-1:0] issue_addr;
	logic [7:0] issue_mask, emit_data;
	coord_t px, py;

	assign start     = q_valid && !out_valid_q && !s1_valid_s1;
	assign line_last = cnt_q == '0;
	assign rect_last = (wx_q == lim_x_q) && (wy_q == lim_y_q);
	assign clr_last  = clr_cnt_q == ADDR_W'(STORE_BYTES - 1);
	assign e2        = err_q - $signed({1'b0, dy_q});
	assign px        = (state_q == BK_LINE && steep_q) ? wy_q : wx_q;
	assign py        = (state_q == BK_LINE && steep_q) ? wx_q : wy_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (start) begin
					case (q_head.cmd)
						CMD_LINE:  state_d = BK_LINE;
						CMD_RECT:  state_d = q_head.skip ? BK_IDLE : BK_RECT;
						CMD_READ:  state_d = q_head.skip ? BK_IDLE : BK_RDWAIT;
						CMD_CLEAR: state_d = BK_CLEAR;
						default:   state_d = BK_IDLE;
					endcase
				end
			end
			BK_LINE:   if (line_last) state_d = BK_IDLE;
			BK_RECT:   if (rect_last) state_d = BK_IDLE;
			BK_CLEAR:  if (clr_last) state_d = BK_IDLE;
			BK_RDWAIT: state_d = BK_IDLE;
			default:   state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop      = 1'b0;
		issue      = 1'b0;
		issue_read = 1'b0;
		issue_addr = pixel_addr(px, py);
		issue_mask = 8'(1) << py[2:0];
		emit       = 1'b0;
		emit_data  = '0;
		clear_we   = 1'b0;
		case (state_q)
			BK_IDLE: begin
				q_pop = start;
				if (start && q_head.cmd == CMD_READ && !q_head.skip) begin
					issue      = 1'b1;
					issue_read = 1'b1;
					issue_addr = pixel_addr(q_head.p0x, q_head.p0y);
				end
				if (start && q_head.skip &&
					(q_head.cmd == CMD_RECT || q_head.cmd == CMD_READ)) begin
					emit = 1'b1;
				end
			end
			BK_LINE: begin
				issue = on_screen(px, py);
				emit  = line_last;
			end
			BK_RECT: begin
				issue = 1'b1;
				emit  = rect_last;
			end
			BK_CLEAR: begin
				clear_we = 1'b1;
				emit     = clr_last && clr_res_q;
			end
			BK_RDWAIT: begin
				emit      = 1'b1;
				emit_data = base_byte;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_cnt_q   <= '0;
			clr_res_q   <= 1'b0;
			s1_valid_s1 <= 1'b0;
			wr_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			s1_valid_s1 <= issue;
			wr_valid_q  <= s2_we;
			if (state_q == BK_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (start && q_head.cmd == CMD_CLEAR && state_q == BK_IDLE) begin
				clr_cnt_q <= '0;
				clr_res_q <= 1'b1;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			wx_q     <= q_head.p0x;
			wy_q     <= q_head.p0y;
			base_y_q <= q_head.p0y;
			lim_x_q  <= q_head.p1x;
			lim_y_q  <= q_head.p1y;
			dx_q     <= q_head.dx;
			dy_q     <= q_head.dy;
			cnt_q    <= q_head.dx;
			err_q    <= $signed({1'b0, q_head.dx} >> 1);
			steep_q  <= q_head.steep;
			neg_q    <= q_head.neg;
			mode_q   <= q_head.mode;
		end else if (state_q == BK_LINE) begin
			wx_q  <= wx_q + 1'b1;
			cnt_q <= cnt_q - 1'b1;
			if (e2 < 0) begin
				wy_q  <= neg_q ? wy_q - 1'b1 : wy_q + 1'b1;
				err_q <= e2 + $signed({1'b0, dx_q});
			end else begin
				err_q <= e2;
			end
		end else if (state_q == BK_RECT) begin
			// advance down the column, then to the next column
			if (wy_q == lim_y_q) begin
				wy_q <= base_y_q;
				wx_q <= wx_q + 1'b1;
			end else begin
				wy_q <= wy_q + 1'b1;
			end
		end
		s1_addr_s1 <= issue_addr;
		s1_mask_s1 <= issue_mask;
		s1_read_s1 <= issue_read;
		s1_mode_s1 <= mode_q;
		if (emit) read_data_q <= emit_data;
	end

	// forward the byte written last cycle; the memory read missed it
	always_comb begin
		base_byte = (wr_valid_q && wr_addr_q == s1_addr_s1) ? wr_data_q : mem_rd_q;
		case (s1_mode_s1)
			MODE_SET:    new_byte = base_byte | s1_mask_s1;
			MODE_CLEAR:  new_byte = base_byte & ~s1_mask_s1;
			MODE_TOGGLE: new_byte = base_byte ^ s1_mask_s1;
			default:     new_byte = base_byte;
		endcase
		s2_we = s1_valid_s1 && !s1_read_s1;
	end

	always_ff @(posedge clk) begin
		if (clear_we) mem[clr_cnt_q] <= '0;
		else if (s2_we) mem[s1_addr_s1] <= new_byte;
		if (issue) mem_rd_q <= mem[issue_addr];
		wr_addr_q <= s1_addr_s1;
		wr_data_q <= new_byte;
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q) else $error("result produced while output full");
	a_no_wr_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(clear_we && s2_we)) else $error("clear and pixel write collide");
	a_rdwait_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == BK_RDWAIT |-> $past(q_pop) && s1_valid_s1 && s1_read_s1)
		else $error("read wait without a read in flight");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid && !s1_valid_s1) else $error("pop while busy");

endmodule

// ===== sv/mono_framebuffer_line_rect_drawer_top.sv =====
// The pixel engine does one pixel read-modify-write a cycle while it walks a line
// or rectangle; it takes the next command only once its last result has left the
// output register and its pixel pipeline is empty.
// Reset clears the frame store; commands queue meanwhile.
// Depends on lrd_pkg, lrd_front, lrd_queue, lrd_back.
module mono_framebuffer_line_rect_drawer_top import lrd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             command,
	input  logic signed [IN_W-1:0] point_a_x,
	input  logic signed [IN_W-1:0] point_a_y,
	input  logic signed [IN_W-1:0] point_b_x,
	input  logic signed [IN_W-1:0] point_b_y,
	input  logic [1:0]             draw_mode,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [7:0]             read_data
);

	logic  q_full, q_push, q_pop, q_valid;
	desc_t q_desc, q_head;

	lrd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.point_a_x (point_a_x),
		.point_a_y (point_a_y),
		.point_b_x (point_b_x),
		.point_b_y (point_b_y),
		.draw_mode (draw_mode),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_desc    (q_desc)
	);

	lrd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_desc),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	lrd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.read_data (read_data)
	);

endmodule
